>>> src/assert_macros.svh
// Assertion macros shared by the sorter RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define QS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("qs assertion failed");
// Condition that must never be true outside reset.
`define QS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("qs forbidden condition seen");
`else
`define QS_ASSERT(lbl, clk, rst_n, prop)
`define QS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/qs_pkg.sv
// Shared constants and types of the quicksort sorter.
`default_nettype none
package qs_pkg;

  // Default store depth and value width.
  localparam int unsigned QS_MAX_ITEMS  = 64;
  localparam int unsigned QS_VALUE_BITS = 32;
  // Fixed width of the value ports.
  localparam int unsigned QS_PORT_BITS  = 32;

  // Sequencer states of the sorter.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_POP,
    ST_PIVOT_RD,
    ST_PIVOT,
    ST_RD_J,
    ST_CMP,
    ST_SW1,
    ST_SW2,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_PUSH_LO,
    ST_PUSH_HI,
    ST_EMIT
  } state_e;

  // Commands to the range stack.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage
`default_nettype wire

>>> src/qs_range_stack.sv
// Stack of pending index ranges, held in a synchronous memory.
`default_nettype none
`include "assert_macros.svh"
module qs_range_stack #(
  parameter int unsigned DEPTH = qs_pkg::QS_MAX_ITEMS / 2,
  parameter int unsigned IDX_W = $clog2(qs_pkg::QS_MAX_ITEMS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire qs_pkg::stk_cmd_t cmd_i,
  input  wire logic [IDX_W-1:0] push_lo_i,
  input  wire logic [IDX_W-1:0] push_hi_i,
  output logic      [IDX_W-1:0] pop_lo_o,
  output logic      [IDX_W-1:0] pop_hi_o,
  output logic                  empty_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W = $clog2(DEPTH + 1);

  logic [2*IDX_W-1:0] mem_q [DEPTH];
  logic [2*IDX_W-1:0] rdata_q;
  logic [PTR_W-1:0]   sp_q, sp_d;
  logic [PTR_W-1:0]   sp_dec;

  assign sp_dec = sp_q - PTR_W'(1);

  // Pointer moves up on a push and down on a pop.
  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q + PTR_W'(1);
    end else if (cmd_i.pop) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // Push writes the free slot; pop reads the top slot into a read register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[sp_q[AW-1:0]] <= {push_lo_i, push_hi_i};
    end
    if (cmd_i.pop) begin
      rdata_q <= mem_q[sp_dec[AW-1:0]];
    end
  end

  assign pop_lo_o = rdata_q[2*IDX_W-1:IDX_W];
  assign pop_hi_o = rdata_q[IDX_W-1:0];
  assign empty_o  = (sp_q == '0);

  `QS_ASSERT(a_push_room, clk_i, rst_ni, cmd_i.push |-> (sp_q < PTR_W'(DEPTH)))
  `QS_ASSERT(a_pop_held, clk_i, rst_ni, cmd_i.pop |-> !empty_o)
  `QS_NEVER(a_push_pop, clk_i, rst_ni, cmd_i.push && cmd_i.pop)

endmodule
`default_nettype wire

>>> src/quicksort_sorter.sv
// Top level of the quicksort sorter: value store, sort sequencer, emission.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  item    | in        | start high while busy low   | item_value_i, last_item_i
//  result  | out       | strobe_o high for one cycle | sorted_value_o, last_result_o,
//          |           |                             | overflow_o
//
// Loading takes every item offered while busy is low. After a last item, the sort
// runs over the value store: each partition has setup and close states, a read
// and a compare per element and two writes more per element swapped. Emission
// then gives one value per cycle. busy stays high from the last item until the
// final result is shown. Reset clears control state only; no clearing pass is run.
`default_nettype none
`include "assert_macros.svh"
module quicksort_sorter #(
  parameter int unsigned MAX_ITEMS  = qs_pkg::QS_MAX_ITEMS,
  parameter int unsigned VALUE_BITS = qs_pkg::QS_VALUE_BITS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic signed [qs_pkg::QS_PORT_BITS-1:0]   item_value_i,
  input  wire logic                                     last_item_i,
  output logic                                          strobe_o,
  output logic signed      [qs_pkg::QS_PORT_BITS-1:0]   sorted_value_o,
  output logic                                          last_result_o,
  output logic                                          overflow_o
);

  localparam int unsigned PW    = qs_pkg::QS_PORT_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned STK_D = MAX_ITEMS / 2;

  qs_pkg::state_e state_q, state_d;

  // Control and datapath registers.
  logic [CNT_W-1:0]      count_q;
  logic                  dropped_q;
  logic [CNT_W-1:0]      k_q;
  logic [IDX_W-1:0]      lo_q, hi_q, i_q, j_q;
  logic [VALUE_BITS-1:0] pivot_q, vj_q;
  logic                  emit_vld_q, emit_last_q, emit_ovf_q;

  // Value store ports.
  logic [VALUE_BITS-1:0] store_q [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;

  // Range stack interface.
  qs_pkg::stk_cmd_t stk_cmd;
  logic [IDX_W-1:0] push_lo, push_hi, pop_lo, pop_hi;
  logic             stk_empty;

  logic                  accept;
  logic                  room;
  logic                  le_pivot;
  logic                  push_lo_ok, push_hi_ok;
  logic                  emit_end;
  logic [VALUE_BITS-1:0] item_ext;
  logic [PW-1:0]         out_ext;

  assign accept   = start && !busy;
  assign room     = (count_q < CNT_W'(MAX_ITEMS));
  assign le_pivot = ($signed(rdata_q) <= $signed(pivot_q));
  assign emit_end = ((k_q + CNT_W'(1)) == count_q);

  // Ranges of two or more values on either side of the pivot go to the stack.
  assign push_lo_ok = ({1'b0, i_q} > ({1'b0, lo_q} + (IDX_W+1)'(1)));
  assign push_hi_ok = ({1'b0, hi_q} > ({1'b0, i_q} + (IDX_W+1)'(1)));

  // Input value to store width, output value sign extended to port width.
  for (genvar b = 0; b < VALUE_BITS; b++) begin : g_in
    if (b < PW) begin : g_bit
      assign item_ext[b] = item_value_i[b];
    end else begin : g_zero
      assign item_ext[b] = 1'b0;
    end
  end
  for (genvar b = 0; b < PW; b++) begin : g_out
    if (b < VALUE_BITS) begin : g_bit
      assign out_ext[b] = rdata_q[b];
    end else begin : g_sign
      assign out_ext[b] = rdata_q[VALUE_BITS-1];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qs_pkg::ST_IDLE: begin
        if (accept && last_item_i) state_d = qs_pkg::ST_SEED;
      end
      qs_pkg::ST_SEED: begin
        if (count_q >= CNT_W'(2)) begin
          state_d = qs_pkg::ST_POP;
        end else if (count_q == '0) begin
          state_d = qs_pkg::ST_IDLE;
        end else begin
          state_d = qs_pkg::ST_EMIT;
        end
      end
      qs_pkg::ST_POP:      state_d = qs_pkg::ST_PIVOT_RD;
      qs_pkg::ST_PIVOT_RD: state_d = qs_pkg::ST_PIVOT;
      qs_pkg::ST_PIVOT:    state_d = qs_pkg::ST_RD_J;
      qs_pkg::ST_RD_J: begin
        state_d = (j_q == hi_q) ? qs_pkg::ST_FIN_W1 : qs_pkg::ST_CMP;
      end
      qs_pkg::ST_CMP: begin
        state_d = (le_pivot && (i_q != j_q)) ? qs_pkg::ST_SW1 : qs_pkg::ST_RD_J;
      end
      qs_pkg::ST_SW1:     state_d = qs_pkg::ST_SW2;
      qs_pkg::ST_SW2:     state_d = qs_pkg::ST_RD_J;
      qs_pkg::ST_FIN_W1:  state_d = qs_pkg::ST_FIN_W2;
      qs_pkg::ST_FIN_W2:  state_d = qs_pkg::ST_PUSH_LO;
      qs_pkg::ST_PUSH_LO: state_d = qs_pkg::ST_PUSH_HI;
      qs_pkg::ST_PUSH_HI: begin
        state_d = (stk_empty && !push_hi_ok) ? qs_pkg::ST_EMIT : qs_pkg::ST_POP;
      end
      qs_pkg::ST_EMIT: begin
        if (emit_end) state_d = qs_pkg::ST_IDLE;
      end
      default: state_d = qs_pkg::ST_IDLE;
    endcase
  end

  // Memory and stack controls for each state.
  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = j_q;
    raddr   = j_q;
    wdata   = rdata_q;
    stk_cmd = '0;
    push_lo = lo_q;
    push_hi = hi_q;
    unique case (state_q)
      qs_pkg::ST_IDLE: begin
        we    = accept && room;
        waddr = count_q[IDX_W-1:0];
        wdata = item_ext;
      end
      qs_pkg::ST_SEED: begin
        stk_cmd.push = (count_q >= CNT_W'(2));
        push_lo      = '0;
        push_hi      = IDX_W'(count_q - CNT_W'(1));
      end
      qs_pkg::ST_POP: begin
        stk_cmd.pop = 1'b1;
      end
      qs_pkg::ST_PIVOT_RD: begin
        re    = 1'b1;
        raddr = pop_hi;
      end
      qs_pkg::ST_RD_J: begin
        re    = 1'b1;
        raddr = (j_q == hi_q) ? i_q : j_q;
      end
      qs_pkg::ST_CMP: begin
        re    = le_pivot && (i_q != j_q);
        raddr = i_q;
      end
      qs_pkg::ST_SW1: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = rdata_q;
      end
      qs_pkg::ST_SW2: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = vj_q;
      end
      qs_pkg::ST_FIN_W1: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = rdata_q;
      end
      qs_pkg::ST_FIN_W2: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = pivot_q;
      end
      qs_pkg::ST_PUSH_LO: begin
        stk_cmd.push = push_lo_ok;
        push_lo      = lo_q;
        push_hi      = i_q - IDX_W'(1);
      end
      qs_pkg::ST_PUSH_HI: begin
        stk_cmd.push = push_hi_ok;
        push_lo      = i_q + IDX_W'(1);
        push_hi      = hi_q;
      end
      qs_pkg::ST_EMIT: begin
        re    = 1'b1;
        raddr = k_q[IDX_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Value store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= store_q[raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qs_pkg::ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      k_q         <= '0;
      emit_vld_q  <= 1'b0;
      emit_last_q <= 1'b0;
      emit_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      emit_vld_q <= 1'b0;
      unique case (state_q)
        qs_pkg::ST_IDLE: begin
          if (accept) begin
            if (room) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        qs_pkg::ST_SEED: begin
          k_q <= '0;
          if (count_q == '0) begin
            dropped_q <= 1'b0;
          end
        end
        qs_pkg::ST_EMIT: begin
          emit_vld_q  <= 1'b1;
          emit_last_q <= emit_end;
          emit_ovf_q  <= dropped_q;
          k_q         <= k_q + CNT_W'(1);
          if (emit_end) begin
            count_q   <= '0;
            dropped_q <= 1'b0;
          end
        end
        default: begin
          k_q <= k_q;
        end
      endcase
    end
  end

  // Partition walk registers: i is the boundary, j the scan index.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      qs_pkg::ST_PIVOT_RD: begin
        lo_q <= pop_lo;
        hi_q <= pop_hi;
      end
      qs_pkg::ST_PIVOT: begin
        pivot_q <= rdata_q;
        i_q     <= lo_q;
        j_q     <= lo_q;
      end
      qs_pkg::ST_CMP: begin
        vj_q <= rdata_q;
        if (le_pivot) begin
          if (i_q == j_q) begin
            i_q <= i_q + IDX_W'(1);
            j_q <= j_q + IDX_W'(1);
          end
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
      qs_pkg::ST_SW2: begin
        i_q <= i_q + IDX_W'(1);
        j_q <= j_q + IDX_W'(1);
      end
      default: begin
        i_q <= i_q;
      end
    endcase
  end

  qs_range_stack #(
    .DEPTH (STK_D),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (stk_cmd),
    .push_lo_i (push_lo),
    .push_hi_i (push_hi),
    .pop_lo_o  (pop_lo),
    .pop_hi_o  (pop_hi),
    .empty_o   (stk_empty)
  );

  // Result ports.
  assign busy           = (state_q != qs_pkg::ST_IDLE);
  assign strobe_o       = emit_vld_q;
  assign sorted_value_o = $signed(out_ext);
  assign last_result_o  = emit_last_q;
  assign overflow_o     = emit_ovf_q;

  `QS_ASSERT(a_last_ends_set, clk_i, rst_ni, (strobe_o && last_result_o) |=> !strobe_o)
  `QS_ASSERT(a_idle_after_last, clk_i, rst_ni, $fell(busy) |-> (strobe_o && last_result_o))
  `QS_ASSERT(a_walk_order, clk_i, rst_ni,
    (state_q == qs_pkg::ST_CMP || state_q == qs_pkg::ST_SW1 || state_q == qs_pkg::ST_SW2)
    |-> ((i_q <= j_q) && (j_q < hi_q)))

endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench for quicksort_sorter: random value sets checked against an in-bench sort.
`timescale 1ns / 100ps
module tb;

  localparam int W         = qs_pkg::QS_PORT_BITS;
  localparam int CAPACITY  = qs_pkg::QS_MAX_ITEMS;
  localparam int ITEM_GOAL = 500;
  localparam int CYCLE_CAP = 500000;

  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  // Value pattern of one set.
  typedef enum int {
    PAT_WIDE,
    PAT_DUPES,
    PAT_EXTREME,
    PAT_ASCENDING
  } pattern_e;

  // One expected output item of a sorted set.
  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    logic                dropped;
  } sorted_entry_t;

  // Keeps the set being loaded and the sorted values still to come out.
  class sort_scoreboard;
    logic signed [W-1:0] held[$];
    bit                  dropped;
    sorted_entry_t       sorted_q[$];
    int                  mismatches;

    // Prints one line per mismatch and counts it.
    task flag(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Stores an accepted item; a last item sorts the set into expectations.
    function void note_item(logic signed [W-1:0] v, logic last);
      logic signed [W-1:0] ordered[$];
      int                  k;
      sorted_entry_t       e;
      if (held.size() < CAPACITY) begin
        held.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        // Insertion keeps equal values together; their order cannot be seen.
        foreach (held[i]) begin
          k = 0;
          while (k < ordered.size() && ordered[k] <= held[i]) k++;
          ordered.insert(k, held[i]);
        end
        foreach (ordered[i]) begin
          e.value   = ordered[i];
          e.last    = (i == ordered.size() - 1);
          e.dropped = dropped;
          sorted_q.push_back(e);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    // Compares one output item with the oldest expectation.
    task check_result(logic signed [W-1:0] v, logic last, logic ovf);
      sorted_entry_t e;
      if (sorted_q.size() == 0) begin
        flag($sformatf("unexpected result value %0d", v));
      end else begin
        e = sorted_q.pop_front();
        if (v !== e.value)
          flag($sformatf("sorted_value %0d, expected %0d", v, e.value));
        if (last !== e.last)
          flag($sformatf("last_result %b, expected %b (value %0d)", last, e.last, e.value));
        if (ovf !== e.dropped)
          flag($sformatf("overflow %b, expected %b (value %0d)", ovf, e.dropped, e.value));
      end
    endtask

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic signed [W-1:0] item_value_i;
  logic                last_item_i;
  logic                strobe_o;
  logic signed [W-1:0] sorted_value_o;
  logic                last_result_o;
  logic                overflow_o;

  sort_scoreboard sb;
  int             items_sent;
  int             cycles = 0;
  bit             quiet;

  quicksort_sorter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_value_i  (item_value_i),
    .last_item_i   (last_item_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .last_result_o (last_result_o),
    .overflow_o    (overflow_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** quicksort_sorter: FAILED **");
      $finish;
    end
  end

  // Observe accepted items and checked results at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_item(item_value_i, last_item_i);
    if (rst_ni && strobe_o) sb.check_result(sorted_value_o, last_result_o, overflow_o);
  end

  // Offers one item, with an occasional random gap first, and waits until it is taken.
  task send_item(logic signed [W-1:0] v, logic last);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      start        <= 1'b0;
      item_value_i <= $urandom;
      last_item_i  <= $urandom_range(0, 1);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start        <= 1'b1;
    item_value_i <= v;
    last_item_i  <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // Holds the sender off until every expected result has come out.
  task settle(int tail);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic signed [W-1:0] pick_value(pattern_e pat);
    int r;
    case (pat)
      PAT_DUPES: begin
        r = $urandom_range(0, 6);
        return r - 3;
      end
      PAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return VMIN;
          1: return VMAX;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Sends one set of n items; the final one is marked last.
  task send_set(int n, pattern_e pat);
    logic signed [W-1:0] v;
    for (int k = 0; k < n; k++) begin
      v = (pat == PAT_ASCENDING) ? (k * 977 - 30000) : pick_value(pat);
      send_item(v, k == n - 1);
    end
  endtask

  initial begin
    int       set_no;
    int       n;
    int       r;
    pattern_e pat;
    sb           = new();
    items_sent   = 0;
    quiet        = 1'b0;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    item_value_i <= '0;
    last_item_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A set of one value.
    send_item(VMAX, 1'b1);
    // Field extremes in mixed order.
    send_item(VMAX, 1'b0);
    send_item(VMIN, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(1, 1'b1);
    // Equal values against the pivot.
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(-5, 1'b0);
    send_item(5, 1'b1);
    // Descending pair, then an already sorted pair.
    send_item(100, 1'b0);
    send_item(-100, 1'b1);
    send_item(VMIN, 1'b0);
    send_item(VMAX, 1'b1);
    settle(8);

    // Random sets; a few fill or overrun the store, most stay small.
    set_no = 0;
    while (items_sent < ITEM_GOAL) begin
      quiet = (set_no >= 15 && set_no < 30);
      r = $urandom_range(0, 9);
      pat = (r < 6) ? PAT_WIDE : (r < 8) ? PAT_DUPES : (r < 9) ? PAT_EXTREME : PAT_ASCENDING;
      if (set_no == 2) begin
        n = CAPACITY + 2;
      end else if (set_no == 5) begin
        n   = CAPACITY;
        pat = PAT_ASCENDING;
      end else if (set_no == 9) begin
        n = CAPACITY + 1;
      end else if ($urandom_range(0, 24) == 0) begin
        n = $urandom_range(CAPACITY - 4, CAPACITY + 6);
      end else begin
        n = $urandom_range(1, 12);
      end
      send_set(n, pat);
      if (set_no % 9 == 4) settle(8);
      set_no++;
    end

    settle(20);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** quicksort_sorter: PASSED **");
    end else begin
      $display("** quicksort_sorter: FAILED **");
    end
    $finish;
  end

endmodule
